// ===== hw/rtl/sblc_pkg.sv =====
// ----------------------------------------------------------------------------
// sblc_pkg
// Shared types and constants of the symbol binding LRU cache: command codes,
// field widths and the request and response transaction structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sblc_pkg;

  // Default cache depth
  localparam int unsigned Entries = 5;

  // Field widths
  localparam int unsigned CmdW   = 2;
  localparam int unsigned KeyW   = 16;
  localparam int unsigned LocW   = 16;
  localparam int unsigned StampW = 32;

  // Command codes; the fourth code is a no-op
  localparam logic [CmdW-1:0] CmdLookup     = 2'd0;
  localparam logic [CmdW-1:0] CmdInsert     = 2'd1;
  localparam logic [CmdW-1:0] CmdInvalidate = 2'd2;

  // Request transaction
  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [KeyW-1:0] symbol_key;
    logic [KeyW-1:0] env_tag;
    logic [LocW-1:0] location_in;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic            hit;
    logic [LocW-1:0] location_out;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sblc_select.sv =====
// ----------------------------------------------------------------------------
// sblc_select
// Parallel tag compare and replacement choice over all entries. Gives one-hot
// vectors for the lookup hit, the invalidate target and the insert victim.
// ----------------------------------------------------------------------------
`default_nettype none

module sblc_select #(
  parameter int unsigned NumEntries = sblc_pkg::Entries
) (
  input  logic                        valid_i   [NumEntries],
  input  logic [sblc_pkg::KeyW-1:0]   symbol_i  [NumEntries],
  input  logic [sblc_pkg::KeyW-1:0]   env_i     [NumEntries],
  input  logic [sblc_pkg::StampW-1:0] stamp_i   [NumEntries],
  input  logic [sblc_pkg::KeyW-1:0]   key_sym_i,
  input  logic [sblc_pkg::KeyW-1:0]   key_env_i,
  output logic [NumEntries-1:0]       lookup_oh_o,
  output logic [NumEntries-1:0]       inval_oh_o,
  output logic [NumEntries-1:0]       victim_oh_o
);

  logic [NumEntries-1:0] sym_match;
  logic [NumEntries-1:0] full_match;
  logic [NumEntries-1:0] first_free;
  logic [NumEntries-1:0] oldest;
  logic                  all_valid;

  // Tag compares
  always_comb begin
    for (int i = 0; i < NumEntries; i++) begin
      sym_match[i]  = valid_i[i] && (symbol_i[i] == key_sym_i);
      full_match[i] = sym_match[i] && (env_i[i] == key_env_i);
    end
  end

  // Lowest-index pick for hits, invalidate target and free entry
  always_comb begin
    logic blk_hit;
    logic blk_inv;
    logic blk_free;
    for (int i = 0; i < NumEntries; i++) begin
      blk_hit  = 1'b0;
      blk_inv  = 1'b0;
      blk_free = 1'b0;
      for (int j = 0; j < i; j++) begin
        blk_hit  = blk_hit  | full_match[j];
        blk_inv  = blk_inv  | sym_match[j];
        blk_free = blk_free | ~valid_i[j];
      end
      lookup_oh_o[i] = full_match[i] & ~blk_hit;
      inval_oh_o[i]  = sym_match[i] & ~blk_inv;
      first_free[i]  = ~valid_i[i] & ~blk_free;
    end
  end

  // Oldest stamp: strictly below lower entries, not above higher ones
  always_comb begin
    for (int i = 0; i < NumEntries; i++) begin
      oldest[i] = 1'b1;
      for (int j = 0; j < NumEntries; j++) begin
        if (j < i) begin
          oldest[i] = oldest[i] & (stamp_i[i] < stamp_i[j]);
        end else if (j > i) begin
          oldest[i] = oldest[i] & (stamp_i[i] <= stamp_i[j]);
        end
      end
    end
  end

  // Empty entries win over any stamp
  always_comb begin
    all_valid = 1'b1;
    for (int i = 0; i < NumEntries; i++) begin
      all_valid = all_valid & valid_i[i];
    end
    victim_oh_o = all_valid ? oldest : first_free;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/symbol_binding_lru_cache.sv =====
// ----------------------------------------------------------------------------
// symbol_binding_lru_cache
// Fully associative cache of symbol bindings tagged by symbol and
// environment, with lookup, LRU-replacing insert and invalidate by symbol.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Payload            | Direction
//  --------+------------------------+--------------------+----------
//  in      | in_valid_i/in_ready_o  | in_data_i  (req_t) | into block
//  out     | out_valid_o/out_ready_i| out_data_o (rsp_t) | out of block
//
//  One command per cycle sustained while responses are taken; a response is
//  offered once its transaction has passed the input register, then the
//  response register.
//  The command is executed by the compare and LRU logic between the two
//  registers; cache state is updated at the edge that loads the response.
//  A stalled response holds the execute stage; the input register still
//  takes one more transaction while the response waits.
//  Reset clears valid bits, the use counter and both stage valids; entry
//  payloads are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module symbol_binding_lru_cache #(
  parameter int unsigned ENTRIES = sblc_pkg::Entries
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sblc_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sblc_pkg::rsp_t out_data_o
);

  // Entry storage
  logic                        valid_q  [ENTRIES];
  logic [sblc_pkg::KeyW-1:0]   symbol_q [ENTRIES];
  logic [sblc_pkg::KeyW-1:0]   env_q    [ENTRIES];
  logic [sblc_pkg::LocW-1:0]   loc_q    [ENTRIES];
  logic [sblc_pkg::StampW-1:0] stamp_q  [ENTRIES];
  logic [sblc_pkg::StampW-1:0] counter_q;

  // Stage registers
  logic           req_valid_q;
  sblc_pkg::req_t req_q;
  logic           rsp_valid_q;
  sblc_pkg::rsp_t rsp_q, rsp_d;

  logic                  advance;
  logic                  exec;
  logic                  do_lookup, do_insert, do_inval;
  logic                  lookup_hit;
  logic [ENTRIES-1:0]    lookup_oh, inval_oh, victim_oh;
  logic [ENTRIES-1:0]    fill_en, stamp_en, clear_en;
  logic [sblc_pkg::LocW-1:0] hit_loc;

  // Handshake
  assign advance     = ~rsp_valid_q | out_ready_i;
  assign exec        = req_valid_q & advance;
  assign in_ready_o  = ~req_valid_q | advance;
  assign out_valid_o = rsp_valid_q;
  assign out_data_o  = rsp_q;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
  end

  // Command decode
  always_comb begin
    do_lookup = 1'b0;
    do_insert = 1'b0;
    do_inval  = 1'b0;
    unique case (req_q.command)
      sblc_pkg::CmdLookup:     do_lookup = 1'b1;
      sblc_pkg::CmdInsert:     do_insert = 1'b1;
      sblc_pkg::CmdInvalidate: do_inval  = 1'b1;
      default: ;
    endcase
  end

  // Compare and replacement choice
  sblc_select #(
    .NumEntries (ENTRIES)
  ) u_select (
    .valid_i     (valid_q),
    .symbol_i    (symbol_q),
    .env_i       (env_q),
    .stamp_i     (stamp_q),
    .key_sym_i   (req_q.symbol_key),
    .key_env_i   (req_q.env_tag),
    .lookup_oh_o (lookup_oh),
    .inval_oh_o  (inval_oh),
    .victim_oh_o (victim_oh)
  );

  // Hit location: AND-OR over the one-hot match
  always_comb begin
    hit_loc = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_loc = hit_loc | (loc_q[i] & {sblc_pkg::LocW{lookup_oh[i]}});
    end
  end

  assign lookup_hit = do_lookup & (|lookup_oh);

  // Per-entry write enables
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      fill_en[i]  = exec & do_insert & victim_oh[i];
      stamp_en[i] = fill_en[i] | (exec & do_lookup & lookup_oh[i]);
      clear_en[i] = exec & do_inval & inval_oh[i];
    end
  end

  // Valid bits and use counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
      end
      counter_q <= '0;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (fill_en[i]) begin
          valid_q[i] <= 1'b1;
        end else if (clear_en[i]) begin
          valid_q[i] <= 1'b0;
        end
      end
      if (exec && (do_insert || lookup_hit)) begin
        counter_q <= counter_q + sblc_pkg::StampW'(1);
      end
    end
  end

  // Entry payloads
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (fill_en[i]) begin
        symbol_q[i] <= req_q.symbol_key;
        env_q[i]    <= req_q.env_tag;
        loc_q[i]    <= req_q.location_in;
      end
      if (stamp_en[i]) begin
        stamp_q[i] <= counter_q;
      end
    end
  end

  // Response register
  always_comb begin
    rsp_d.hit          = lookup_hit;
    rsp_d.location_out = lookup_hit ? hit_loc : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sblc_checker.sv =====
// ----------------------------------------------------------------------------
// sblc_checker
// Port-level checks of the symbol binding LRU cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sblc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input sblc_pkg::req_t in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input sblc_pkg::rsp_t out_data_o
);

  // A stalled response holds its transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("response dropped or changed while stalled");

  // A miss never carries a location
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.location_out == '0)
    else $error("location on a miss response");

  // Input back-pressure only while a response waits
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending response");

  // A fresh response follows an accepted transaction through both registers
  a_rsp_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("response without an accepted transaction");

endmodule

bind symbol_binding_lru_cache sblc_checker u_sblc_checker (.*);

`default_nettype wire
